@@ rtl/core/emh_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and register codes for the entropy health monitor.
package emh_pkg;

    // Default block parameters
    localparam int DEF_NUM_SOURCES     = 2;
    localparam int DEF_WINDOW_SIZE     = 512;
    localparam int DEF_STARTUP_SAMPLES = 1024;
    localparam int DEF_SYMBOL_LEVELS   = 16;

    // Fixed field widths
    localparam int TS_W       = 32;
    localparam int RCT_W      = 16;
    localparam int APT_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Counter saturation points
    localparam logic [RCT_W-1:0] RCT_MAX = '1;
    localparam logic [APT_W-1:0] APT_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEALTH_ENABLED       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIPS_MODE            = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RCT_CUTOFF           = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RCT_CUTOFF_PERMANENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_APT_CUTOFF           = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_APT_CUTOFF_PERMANENT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HALT_ON_PERMANENT    = 3'd6;

    // Configuration reset values
    localparam logic [RCT_W-1:0] RST_RCT_CUTOFF           = 16'd31;
    localparam logic [RCT_W-1:0] RST_RCT_CUTOFF_PERMANENT = 16'd81;
    localparam logic [APT_W-1:0] RST_APT_CUTOFF           = 10'd325;
    localparam logic [APT_W-1:0] RST_APT_CUTOFF_PERMANENT = 10'd371;

    // Verdict codes
    localparam logic [1:0] VERDICT_PASS    = 2'd0;
    localparam logic [1:0] VERDICT_DROPPED = 2'd1;
    localparam logic [1:0] VERDICT_USABLE  = 2'd2;
    localparam logic [1:0] VERDICT_UNUSED  = 2'd3;

    // Configuration register set
    typedef struct packed {
        logic             health_enabled;
        logic             fips_mode;
        logic [RCT_W-1:0] rct_cutoff;
        logic [RCT_W-1:0] rct_cutoff_permanent;
        logic [APT_W-1:0] apt_cutoff;
        logic [APT_W-1:0] apt_cutoff_permanent;
        logic             halt_on_permanent;
    } cfg_t;

    // Result flags of one item
    typedef struct packed {
        logic [1:0] verdict;
        logic       startup_done;
        logic       compliant;
        logic       reset_entropy;
        logic       permanent_failure;
        logic       halted;
    } result_t;

endpackage

@@ rtl/core/entropy_health_monitor_core.sv @@
`timescale 1ns / 1ps
// Top level of the entropy health monitor: item register, per-source state, result register.
//
// Health tests for raw noise-source timestamps (stuck, repetition count and adaptive
// proportion tests). One item is accepted per cycle while results drain. The item waits
// in the item register, and its result is then offered from the result register.
// A new item can enter every cycle as long as results are taken. Each accepted
// item is tested combinationally between the item register and the result register, and the
// state of its source is written back at that same edge, so items from the same source
// may follow each other without gaps. Configuration is written through a plain write port
// and should only change while no item is in flight. Each source runs its startup blocks after reset.
module entropy_health_monitor_core
    import emh_pkg::*;
#(
    parameter int NUM_SOURCES     = DEF_NUM_SOURCES,
    parameter int WINDOW_SIZE     = DEF_WINDOW_SIZE,
    parameter int STARTUP_SAMPLES = DEF_STARTUP_SAMPLES,
    parameter int SYMBOL_LEVELS   = DEF_SYMBOL_LEVELS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TS_W-1:0]       timestamp,
    input  logic                  source,
    // result items
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            verdict,
    output logic                  startup_done,
    output logic                  compliant,
    output logic                  reset_entropy,
    output logic                  permanent_failure,
    output logic                  halted
);

    localparam int BLOCKS = (STARTUP_SAMPLES + WINDOW_SIZE - 1) / WINDOW_SIZE;
    localparam int WL_W   = $clog2(WINDOW_SIZE + 1);
    localparam int BLK_W  = $clog2(BLOCKS + 1);
    localparam int SYM_W  = $clog2(SYMBOL_LEVELS);
    localparam int SRC_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

    cfg_t cfg;

    // item register
    logic             item_valid_reg;
    logic             item_valid_next;
    logic [TS_W-1:0]  item_ts_reg;
    logic [SRC_W-1:0] item_src_reg;
    logic [SRC_W-1:0] src_idx;
    logic             in_accept;
    logic             advance;

    // per-source state
    logic [TS_W-1:0]  prev_time_reg           [NUM_SOURCES];
    logic [TS_W-1:0]  prev_delta_reg          [NUM_SOURCES];
    logic [TS_W-1:0]  prev_delta2_reg         [NUM_SOURCES];
    logic [RCT_W-1:0] repeat_count_reg        [NUM_SOURCES];
    logic [APT_W-1:0] match_count_reg         [NUM_SOURCES];
    logic [SYM_W-1:0] match_base_reg          [NUM_SOURCES];
    logic             base_valid_reg          [NUM_SOURCES];
    logic [WL_W-1:0]  window_left_reg         [NUM_SOURCES];
    logic [BLK_W-1:0] startup_blocks_left_reg [NUM_SOURCES];
    logic             startup_complete_reg    [NUM_SOURCES];
    logic             halt_flag_reg;

    logic [TS_W-1:0]  prev_time_next;
    logic [TS_W-1:0]  prev_delta_next;
    logic [TS_W-1:0]  prev_delta2_next;
    logic [RCT_W-1:0] repeat_count_next;
    logic [APT_W-1:0] match_count_next;
    logic [SYM_W-1:0] match_base_next;
    logic             base_valid_next;
    logic [WL_W-1:0]  window_left_next;
    logic [BLK_W-1:0] startup_blocks_left_next;
    logic             startup_complete_next;
    logic             halt_flag_next;

    // result register
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;
    result_t result_next;

    emh_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: the item moves on whenever the result register is free or drains
    assign advance   = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    // Source index is the source bit, forced to zero with a single source
    assign src_idx = (NUM_SOURCES > 1) ? SRC_W'(source) : '0;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_ts_reg  <= timestamp;
            item_src_reg <= src_idx;
        end
    end

    // Tests for the held item against its source's state
    emh_calc #(
        .WINDOW_SIZE     (WINDOW_SIZE),
        .STARTUP_SAMPLES (STARTUP_SAMPLES),
        .SYMBOL_LEVELS   (SYMBOL_LEVELS)
    ) u_calc (
        .cfg                     (cfg),
        .timestamp               (item_ts_reg),
        .prev_time               (prev_time_reg[item_src_reg]),
        .prev_delta              (prev_delta_reg[item_src_reg]),
        .prev_delta2             (prev_delta2_reg[item_src_reg]),
        .repeat_count            (repeat_count_reg[item_src_reg]),
        .match_count             (match_count_reg[item_src_reg]),
        .match_base              (match_base_reg[item_src_reg]),
        .base_valid              (base_valid_reg[item_src_reg]),
        .window_left             (window_left_reg[item_src_reg]),
        .startup_blocks_left     (startup_blocks_left_reg[item_src_reg]),
        .startup_complete        (startup_complete_reg[item_src_reg]),
        .halt_flag               (halt_flag_reg),
        .prev_time_upd           (prev_time_next),
        .prev_delta_upd          (prev_delta_next),
        .prev_delta2_upd         (prev_delta2_next),
        .repeat_count_upd        (repeat_count_next),
        .match_count_upd         (match_count_next),
        .match_base_upd          (match_base_next),
        .base_valid_upd          (base_valid_next),
        .window_left_upd         (window_left_next),
        .startup_blocks_left_upd (startup_blocks_left_next),
        .startup_complete_upd    (startup_complete_next),
        .halt_flag_upd           (halt_flag_next),
        .result                  (result_next)
    );

    // State write-back for the item's source
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                prev_time_reg[i]           <= '0;
                prev_delta_reg[i]          <= '0;
                prev_delta2_reg[i]         <= '0;
                repeat_count_reg[i]        <= '0;
                match_count_reg[i]         <= '0;
                match_base_reg[i]          <= '0;
                base_valid_reg[i]          <= 1'b0;
                window_left_reg[i]         <= WL_W'(WINDOW_SIZE);
                startup_blocks_left_reg[i] <= BLK_W'(BLOCKS);
                startup_complete_reg[i]    <= 1'b0;
            end
            halt_flag_reg <= 1'b0;
        end
        else if (advance)
        begin
            prev_time_reg[item_src_reg]           <= prev_time_next;
            prev_delta_reg[item_src_reg]          <= prev_delta_next;
            prev_delta2_reg[item_src_reg]         <= prev_delta2_next;
            repeat_count_reg[item_src_reg]        <= repeat_count_next;
            match_count_reg[item_src_reg]         <= match_count_next;
            match_base_reg[item_src_reg]          <= match_base_next;
            base_valid_reg[item_src_reg]          <= base_valid_next;
            window_left_reg[item_src_reg]         <= window_left_next;
            startup_blocks_left_reg[item_src_reg] <= startup_blocks_left_next;
            startup_complete_reg[item_src_reg]    <= startup_complete_next;
            halt_flag_reg                         <= halt_flag_next;
        end
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign verdict           = result_reg.verdict;
    assign startup_done      = result_reg.startup_done;
    assign compliant         = result_reg.compliant;
    assign reset_entropy     = result_reg.reset_entropy;
    assign permanent_failure = result_reg.permanent_failure;
    assign halted            = result_reg.halted;

    // Checks
    a_perm_implies_reset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.permanent_failure |-> result_reg.reset_entropy)
        else $error("permanent failure without entropy reset");

    a_compliant_implies_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.compliant |-> result_reg.startup_done)
        else $error("compliant while startup not done");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> result_reg.verdict != VERDICT_UNUSED)
        else $error("unused verdict code");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_flag_reg |=> halt_flag_reg)
        else $error("halt flag cleared");

    a_startup_blocks_spent: assert property (@(posedge clk) disable iff (!rst_n)
        startup_complete_reg[0] |-> startup_blocks_left_reg[0] == '0)
        else $error("startup complete with blocks left");

endmodule

@@ rtl/core/emh_cfg_regs.sv @@
`timescale 1ns / 1ps
// Configuration register file of the entropy health monitor.
module emh_cfg_regs
    import emh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_HEALTH_ENABLED:       cfg_next.health_enabled = cfg_data[0];
                CFG_FIPS_MODE:            cfg_next.fips_mode = cfg_data[0];
                CFG_RCT_CUTOFF:           cfg_next.rct_cutoff = cfg_data[RCT_W-1:0];
                CFG_RCT_CUTOFF_PERMANENT: cfg_next.rct_cutoff_permanent = cfg_data[RCT_W-1:0];
                CFG_APT_CUTOFF:           cfg_next.apt_cutoff = cfg_data[APT_W-1:0];
                CFG_APT_CUTOFF_PERMANENT: cfg_next.apt_cutoff_permanent = cfg_data[APT_W-1:0];
                CFG_HALT_ON_PERMANENT:    cfg_next.halt_on_permanent = cfg_data[0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.health_enabled       <= 1'b1;
            cfg_reg.fips_mode            <= 1'b1;
            cfg_reg.rct_cutoff           <= RST_RCT_CUTOFF;
            cfg_reg.rct_cutoff_permanent <= RST_RCT_CUTOFF_PERMANENT;
            cfg_reg.apt_cutoff           <= RST_APT_CUTOFF;
            cfg_reg.apt_cutoff_permanent <= RST_APT_CUTOFF_PERMANENT;
            cfg_reg.halt_on_permanent    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/emh_calc.sv @@
`timescale 1ns / 1ps
// Combinational health tests: next state of one source and the item's result flags.
module emh_calc
    import emh_pkg::*;
#(
    parameter int WINDOW_SIZE     = DEF_WINDOW_SIZE,
    parameter int STARTUP_SAMPLES = DEF_STARTUP_SAMPLES,
    parameter int SYMBOL_LEVELS   = DEF_SYMBOL_LEVELS,
    localparam int BLOCKS = (STARTUP_SAMPLES + WINDOW_SIZE - 1) / WINDOW_SIZE,
    localparam int WL_W   = $clog2(WINDOW_SIZE + 1),
    localparam int BLK_W  = $clog2(BLOCKS + 1),
    localparam int SYM_W  = $clog2(SYMBOL_LEVELS)
)
(
    input  cfg_t             cfg,
    input  logic [TS_W-1:0]  timestamp,
    // current state of the selected source
    input  logic [TS_W-1:0]  prev_time,
    input  logic [TS_W-1:0]  prev_delta,
    input  logic [TS_W-1:0]  prev_delta2,
    input  logic [RCT_W-1:0] repeat_count,
    input  logic [APT_W-1:0] match_count,
    input  logic [SYM_W-1:0] match_base,
    input  logic             base_valid,
    input  logic [WL_W-1:0]  window_left,
    input  logic [BLK_W-1:0] startup_blocks_left,
    input  logic             startup_complete,
    input  logic             halt_flag,
    // updated state
    output logic [TS_W-1:0]  prev_time_upd,
    output logic [TS_W-1:0]  prev_delta_upd,
    output logic [TS_W-1:0]  prev_delta2_upd,
    output logic [RCT_W-1:0] repeat_count_upd,
    output logic [APT_W-1:0] match_count_upd,
    output logic [SYM_W-1:0] match_base_upd,
    output logic             base_valid_upd,
    output logic [WL_W-1:0]  window_left_upd,
    output logic [BLK_W-1:0] startup_blocks_left_upd,
    output logic             startup_complete_upd,
    output logic             halt_flag_upd,
    output result_t          result
);

    localparam logic [WL_W-1:0]  WINDOW_RELOAD = WL_W'(WINDOW_SIZE);
    localparam logic [BLK_W-1:0] BLOCK_RELOAD  = BLK_W'(BLOCKS);
    localparam logic [SYM_W-1:0] SYM_MASK      = SYM_W'(SYMBOL_LEVELS - 1);

    logic [SYM_W-1:0] sym;
    logic [TS_W-1:0]  d1;
    logic [TS_W-1:0]  d2;
    logic [TS_W-1:0]  d3;
    logic             stuck;
    logic             fail;
    logic             perm;
    logic             active;

    assign sym = timestamp[SYM_W-1:0] & SYM_MASK;

    // Wrapped differences against the stored history
    assign d1    = timestamp - prev_time;
    assign d2    = d1 - prev_delta;
    assign d3    = d2 - prev_delta2;
    assign stuck = (d1 == '0) || (d2 == '0) || (d3 == '0);

    // Proportion test, then stuck history, then repetition test
    always_comb
    begin
        prev_time_upd           = prev_time;
        prev_delta_upd          = prev_delta;
        prev_delta2_upd         = prev_delta2;
        repeat_count_upd        = repeat_count;
        match_count_upd         = match_count;
        match_base_upd          = match_base;
        base_valid_upd          = base_valid;
        window_left_upd         = window_left;
        startup_blocks_left_upd = startup_blocks_left;
        startup_complete_upd    = startup_complete;
        halt_flag_upd           = halt_flag;
        fail                    = 1'b0;
        perm                    = 1'b0;

        if (cfg.health_enabled)
        begin
            // adaptive proportion test
            if (cfg.fips_mode)
            begin
                if (!base_valid)
                begin
                    match_base_upd = sym;
                    base_valid_upd = 1'b1;
                end
                else
                begin
                    if (sym == match_base)
                    begin
                        if (match_count != APT_MAX)
                        begin
                            match_count_upd = match_count + 1'b1;
                        end
                        if (match_count_upd >= cfg.apt_cutoff_permanent)
                        begin
                            perm                    = 1'b1;
                            fail                    = 1'b1;
                            startup_blocks_left_upd = BLOCK_RELOAD;
                            startup_complete_upd    = 1'b0;
                            repeat_count_upd        = '0;
                            match_count_upd         = '0;
                            match_base_upd          = '0;
                            window_left_upd         = WINDOW_RELOAD;
                        end
                        else if (match_count_upd >= cfg.apt_cutoff)
                        begin
                            fail                    = 1'b1;
                            startup_blocks_left_upd = BLOCK_RELOAD;
                            startup_complete_upd    = 1'b0;
                        end
                    end
                    if (window_left_upd != '0)
                    begin
                        window_left_upd = window_left_upd - 1'b1;
                    end
                    // window end: restart, and consume a startup block while startup is incomplete
                    if (window_left_upd == '0)
                    begin
                        window_left_upd = WINDOW_RELOAD;
                        match_count_upd = '0;
                        match_base_upd  = sym;
                        if (!startup_complete_upd)
                        begin
                            if (startup_blocks_left_upd != '0)
                            begin
                                startup_blocks_left_upd = startup_blocks_left_upd - 1'b1;
                            end
                            if (startup_blocks_left_upd == '0)
                            begin
                                startup_complete_upd = 1'b1;
                            end
                        end
                    end
                end
            end

            // stuck test history
            prev_time_upd   = timestamp;
            prev_delta_upd  = d1;
            prev_delta2_upd = d2;

            // repetition count test
            if (cfg.fips_mode)
            begin
                if (!stuck)
                begin
                    repeat_count_upd = '0;
                end
                else
                begin
                    if (repeat_count_upd != RCT_MAX)
                    begin
                        repeat_count_upd = repeat_count_upd + 1'b1;
                    end
                    if (repeat_count_upd >= cfg.rct_cutoff_permanent)
                    begin
                        perm                    = 1'b1;
                        fail                    = 1'b1;
                        startup_blocks_left_upd = BLOCK_RELOAD;
                        startup_complete_upd    = 1'b0;
                        repeat_count_upd        = '0;
                        match_count_upd         = '0;
                        match_base_upd          = '0;
                        window_left_upd         = WINDOW_RELOAD;
                    end
                    else if (repeat_count_upd >= cfg.rct_cutoff)
                    begin
                        fail                    = 1'b1;
                        startup_blocks_left_upd = BLOCK_RELOAD;
                        startup_complete_upd    = 1'b0;
                    end
                end
            end

            if (perm && cfg.halt_on_permanent)
            begin
                halt_flag_upd = 1'b1;
            end
        end
    end

    // Result flags
    assign active = cfg.health_enabled && cfg.fips_mode;

    always_comb
    begin
        result.verdict = VERDICT_PASS;
        if (cfg.health_enabled && stuck)
        begin
            result.verdict = cfg.fips_mode ? VERDICT_DROPPED : VERDICT_USABLE;
        end
        result.startup_done      = active ? startup_complete_upd : 1'b1;
        result.compliant         = active && startup_complete_upd;
        result.reset_entropy     = fail;
        result.permanent_failure = perm;
        result.halted            = halt_flag_upd;
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the entropy health monitor core: stimulus, predictor, checker.
module tb_top;
    import emh_pkg::*;

    localparam int WIN_LEN     = DEF_WINDOW_SIZE;
    localparam int BOOT_BLOCKS = (DEF_STARTUP_SAMPLES + DEF_WINDOW_SIZE - 1) / DEF_WINDOW_SIZE;
    localparam int SRC_COUNT   = DEF_NUM_SOURCES;
    localparam logic [TS_W-1:0] SYM_MASK = DEF_SYMBOL_LEVELS - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    // Shapes of timestamp runs
    typedef enum int {
        RUN_NOISE,
        RUN_REPEAT,
        RUN_STEP,
        RUN_CURVE,
        RUN_NIBBLE
    } run_kind_e;

    // DUT connections
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [TS_W-1:0]       timestamp = '0;
    logic                  source    = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            verdict;
    logic                  startup_done;
    logic                  compliant;
    logic                  reset_entropy;
    logic                  permanent_failure;
    logic                  halted;

    // Predictor: configuration mirror and per-source history
    cfg_t              model_cfg;
    logic [TS_W-1:0]   last_ts     [SRC_COUNT];
    logic [TS_W-1:0]   last_d1     [SRC_COUNT];
    logic [TS_W-1:0]   last_d2     [SRC_COUNT];
    logic [RCT_W-1:0]  stuck_run   [SRC_COUNT];
    logic [APT_W-1:0]  sym_hits    [SRC_COUNT];
    logic [3:0]        sym_base    [SRC_COUNT];
    logic              sym_base_ok [SRC_COUNT];
    logic [APT_W-1:0]  win_left    [SRC_COUNT];
    logic [7:0]        boot_left   [SRC_COUNT];
    logic              boot_done   [SRC_COUNT];
    logic              halt_latched;
    logic              step_reset;
    logic              step_perm;

    result_t expected_q[$];
    int      errors       = 0;
    int      results_seen = 0;
    int      quiet_cycles = 0;
    int      stall_left   = 0;
    int      stall_len    = 0;
    bit      idle_on      = 1'b1;

    entropy_health_monitor_core u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .timestamp         (timestamp),
        .source            (source),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .verdict           (verdict),
        .startup_done      (startup_done),
        .compliant         (compliant),
        .reset_entropy     (reset_entropy),
        .permanent_failure (permanent_failure),
        .halted            (halted)
    );

    always #1 clk = ~clk;

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // ---------------------------------------------------------------- predictor

    task automatic init_health_model();
        model_cfg.health_enabled       = 1'b1;
        model_cfg.fips_mode            = 1'b1;
        model_cfg.rct_cutoff           = RST_RCT_CUTOFF;
        model_cfg.rct_cutoff_permanent = RST_RCT_CUTOFF_PERMANENT;
        model_cfg.apt_cutoff           = RST_APT_CUTOFF;
        model_cfg.apt_cutoff_permanent = RST_APT_CUTOFF_PERMANENT;
        model_cfg.halt_on_permanent    = 1'b0;
        for (int s = 0; s < SRC_COUNT; s++)
        begin
            last_ts[s]     = '0;
            last_d1[s]     = '0;
            last_d2[s]     = '0;
            stuck_run[s]   = '0;
            sym_hits[s]    = '0;
            sym_base[s]    = '0;
            sym_base_ok[s] = 1'b0;
            win_left[s]    = APT_W'(WIN_LEN);
            boot_left[s]   = 8'(BOOT_BLOCKS);
            boot_done[s]   = 1'b0;
        end
        halt_latched = 1'b0;
    endtask

    // Any failure restarts startup gating
    function automatic void mark_failure(int s);
        step_reset   = 1'b1;
        boot_left[s] = 8'(BOOT_BLOCKS);
        boot_done[s] = 1'b0;
    endfunction

    // Permanent failure also clears the counters (base stays valid)
    function automatic void mark_permanent(int s);
        step_perm = 1'b1;
        if (model_cfg.halt_on_permanent)
            halt_latched = 1'b1;
        mark_failure(s);
        stuck_run[s] = '0;
        sym_hits[s]  = '0;
        sym_base[s]  = '0;
        win_left[s]  = APT_W'(WIN_LEN);
    endfunction

    function automatic result_t predict_health(logic [TS_W-1:0] ts, logic src);
        logic [3:0]      sym;
        logic [TS_W-1:0] d1;
        logic [TS_W-1:0] d2;
        logic [TS_W-1:0] d3;
        logic            stuck;
        logic            active;
        int              s;
        result_t         r;
        s          = int'(src) % SRC_COUNT;
        sym        = 4'(ts & SYM_MASK);
        stuck      = 1'b0;
        step_reset = 1'b0;
        step_perm  = 1'b0;
        r          = '0;
        r.verdict  = VERDICT_PASS;
        if (model_cfg.health_enabled)
        begin
            // proportion test
            if (model_cfg.fips_mode)
            begin
                if (!sym_base_ok[s])
                begin
                    sym_base[s]    = sym;
                    sym_base_ok[s] = 1'b1;
                end
                else
                begin
                    if (sym == sym_base[s])
                    begin
                        if (sym_hits[s] != APT_MAX)
                            sym_hits[s] = sym_hits[s] + 1'b1;
                        if (sym_hits[s] >= model_cfg.apt_cutoff_permanent)
                            mark_permanent(s);
                        else if (sym_hits[s] >= model_cfg.apt_cutoff)
                            mark_failure(s);
                    end
                    if (win_left[s] > 0)
                        win_left[s] = win_left[s] - 1'b1;
                    if (win_left[s] == 0)
                    begin
                        win_left[s] = APT_W'(WIN_LEN);
                        sym_hits[s] = '0;
                        sym_base[s] = sym;
                        if (!boot_done[s])
                        begin
                            if (boot_left[s] > 0)
                                boot_left[s] = boot_left[s] - 1'b1;
                            if (boot_left[s] == 0)
                                boot_done[s] = 1'b1;
                        end
                    end
                end
            end
            // stuck test on wrapped differences
            d1 = ts - last_ts[s];
            d2 = d1 - last_d1[s];
            d3 = d2 - last_d2[s];
            last_ts[s] = ts;
            last_d1[s] = d1;
            last_d2[s] = d2;
            stuck = (d1 == 0) || (d2 == 0) || (d3 == 0);
            // repetition count test
            if (model_cfg.fips_mode)
            begin
                if (!stuck)
                    stuck_run[s] = '0;
                else
                begin
                    if (stuck_run[s] != RCT_MAX)
                        stuck_run[s] = stuck_run[s] + 1'b1;
                    if (stuck_run[s] >= model_cfg.rct_cutoff_permanent)
                        mark_permanent(s);
                    else if (stuck_run[s] >= model_cfg.rct_cutoff)
                        mark_failure(s);
                end
            end
            if (stuck)
                r.verdict = model_cfg.fips_mode ? VERDICT_DROPPED : VERDICT_USABLE;
        end
        active              = model_cfg.health_enabled && model_cfg.fips_mode;
        r.startup_done      = active ? boot_done[s] : 1'b1;
        r.compliant         = active && boot_done[s];
        r.reset_entropy     = step_reset;
        r.permanent_failure = step_perm;
        r.halted            = halt_latched;
        return r;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            CFG_HEALTH_ENABLED:       model_cfg.health_enabled       = data[0];
            CFG_FIPS_MODE:            model_cfg.fips_mode            = data[0];
            CFG_RCT_CUTOFF:           model_cfg.rct_cutoff           = data;
            CFG_RCT_CUTOFF_PERMANENT: model_cfg.rct_cutoff_permanent = data;
            CFG_APT_CUTOFF:           model_cfg.apt_cutoff           = data[APT_W-1:0];
            CFG_APT_CUTOFF_PERMANENT: model_cfg.apt_cutoff_permanent = data[APT_W-1:0];
            CFG_HALT_ON_PERMANENT:    model_cfg.halt_on_permanent    = data[0];
            default: ;
        endcase
    endtask

    // Flag registers, with junk in the unused upper bits
    task automatic set_mode(logic health, logic fips, logic halt);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(CFG_HEALTH_ENABLED, {junk[15:1], health});
        junk = CFG_DATA_W'($urandom);
        write_reg(CFG_FIPS_MODE, {junk[15:1], fips});
        junk = CFG_DATA_W'($urandom);
        write_reg(CFG_HALT_ON_PERMANENT, {junk[15:1], halt});
    endtask

    task automatic set_cutoffs(logic [RCT_W-1:0] rct, logic [RCT_W-1:0] rct_perm,
                               logic [APT_W-1:0] apt, logic [APT_W-1:0] apt_perm);
        logic [CFG_DATA_W-1:0] junk;
        write_reg(CFG_RCT_CUTOFF, rct);
        write_reg(CFG_RCT_CUTOFF_PERMANENT, rct_perm);
        junk = CFG_DATA_W'($urandom);
        write_reg(CFG_APT_CUTOFF, {junk[15:10], apt});
        junk = CFG_DATA_W'($urandom);
        write_reg(CFG_APT_CUTOFF_PERMANENT, {junk[15:10], apt_perm});
    endtask

    // Offer one item; the expectation is queued when it is taken
    task automatic send_item(logic [TS_W-1:0] ts, logic src);
        int gap;
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        timestamp = ts;
        source    = src;
        in_valid  = 1'b1;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        expected_q.push_back(predict_health(ts, src));
    endtask

    // A run of timestamps of one shape on one source
    task automatic send_run(run_kind_e kind, int len, logic src);
        logic [TS_W-1:0] ts;
        logic [TS_W-1:0] step;
        logic [TS_W-1:0] accel;
        logic [3:0]      nib;
        int              i;
        ts    = $urandom;
        step  = $urandom;
        accel = $urandom;
        nib   = 4'($urandom);
        if ($urandom_range(0, 3) == 0)
            step = $urandom_range(0, 3);
        for (i = 0; i < len; i++)
        begin
            case (kind)
                RUN_NOISE:  ts = $urandom;
                RUN_REPEAT: ;
                RUN_STEP:   ts = ts + step;
                RUN_CURVE:
                begin
                    ts   = ts + step;
                    step = step + accel;
                end
                RUN_NIBBLE: ts = ($urandom & ~SYM_MASK) | TS_W'(nib);
                default: ;
            endcase
            send_item(ts, src);
        end
    endtask

    // Drop valid and wait until every queued result is back
    task automatic wait_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_cut(int top);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'd0;
        if (r == 1)
            return 16'(top);
        if (r < 7)
            return 16'($urandom_range(1, 12));
        return 16'($urandom_range(1, top));
    endfunction

    // ---------------------------------------------------------------- sink and checker

    // Result side backpressure
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            stall_len = pick_gap();
            if (stall_len > 0)
            begin
                out_ready  <= 1'b0;
                stall_left = stall_len - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each result item with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                if (errors < MAX_REPORTS)
                    $display("result %0d: no item outstanding", results_seen);
                errors = errors + 1;
            end
            else
            begin
                result_t want;
                want = expected_q.pop_front();
                if (verdict !== want.verdict || startup_done !== want.startup_done ||
                    compliant !== want.compliant || reset_entropy !== want.reset_entropy ||
                    permanent_failure !== want.permanent_failure || halted !== want.halted)
                begin
                    if (errors < MAX_REPORTS)
                        $display("result %0d: exp v=%0d sd=%0d c=%0d re=%0d pf=%0d h=%0d,",
                                 results_seen, want.verdict, want.startup_done,
                                 want.compliant, want.reset_entropy,
                                 want.permanent_failure, want.halted,
                                 " got v=%0d sd=%0d c=%0d re=%0d pf=%0d h=%0d",
                                 verdict, startup_done, compliant, reset_entropy,
                                 permanent_failure, halted);
                    errors = errors + 1;
                end
            end
            results_seen = results_seen + 1;
        end
    end

    // Watchdog on handshake activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // Field extremes and the three kinds of stuck timestamps, at reset settings
    task automatic test_directed();
        send_item(32'h0000_0000, 1'b0);   // equals the zero history
        send_item(32'hFFFF_FFFF, 1'b1);
        send_item(32'hFFFF_FFFF, 1'b1);   // repeated value
        send_item(32'h0000_0000, 1'b1);   // wraps around
        send_item(32'd100, 1'b0);
        send_item(32'd200, 1'b0);         // constant step
        send_item(32'd400, 1'b0);
        send_item(32'd700, 1'b0);         // constant second difference
        send_item(32'hAAAA_AAAA, 1'b0);
        send_item(32'h5555_5555, 1'b1);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b1);
        send_run(RUN_NOISE, 3, 1'b0);
        send_run(RUN_NOISE, 3, 1'b1);
        wait_results();
    endtask

    // A clean window consumes a startup block, then a repetition failure restarts gating
    task automatic test_startup();
        send_run(RUN_NOISE, 530, 1'b0);
        send_run(RUN_REPEAT, 32, 1'b0);
        send_run(RUN_NOISE, 4, 1'b0);
        wait_results();
    endtask

    // Health tests off: everything passes and history is left alone
    task automatic test_bypass();
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        set_mode(1'b0, 1'b1, 1'b0);
        send_run(RUN_REPEAT, 6, 1'b1);
        send_run(RUN_STEP, 6, 1'b0);
        send_run(RUN_NIBBLE, 6, 1'b1);
        wait_results();
        set_mode(1'b1, 1'b1, 1'b0);
        send_run(RUN_REPEAT, 4, 1'b1);
        send_run(RUN_NOISE, 4, 1'b0);
        wait_results();
    endtask

    // Fips mode off: stuck items stay usable and no counters run
    task automatic test_plain_stuck();
        set_cutoffs(16'd1, 16'd2, 10'd1, 10'd2);
        set_mode(1'b1, 1'b0, 1'b0);
        send_run(RUN_REPEAT, 6, 1'b0);
        send_run(RUN_STEP, 6, 1'b1);
        send_run(RUN_CURVE, 8, 1'b0);
        send_run(RUN_NIBBLE, 8, 1'b1);
        send_run(RUN_NOISE, 4, 1'b1);
        wait_results();
        set_mode(1'b1, 1'b1, 1'b0);
    endtask

    // Repetition count cutoffs, including zero and maximum
    task automatic test_repetition();
        set_cutoffs(16'd3, 16'd6, RST_APT_CUTOFF, RST_APT_CUTOFF_PERMANENT);
        send_run(RUN_REPEAT, 10, 1'b0);
        send_run(RUN_STEP, 10, 1'b1);
        send_run(RUN_CURVE, 10, 1'b0);
        send_run(RUN_NOISE, 3, 1'b0);
        wait_results();
        set_cutoffs(16'd0, 16'd0, RST_APT_CUTOFF, RST_APT_CUTOFF_PERMANENT);
        send_run(RUN_REPEAT, 4, 1'b1);
        send_run(RUN_NOISE, 3, 1'b1);
        wait_results();
        set_cutoffs(16'd0, RCT_MAX, RST_APT_CUTOFF, RST_APT_CUTOFF_PERMANENT);
        send_run(RUN_REPEAT, 4, 1'b0);
        wait_results();
        set_cutoffs(RCT_MAX, 16'd5, RST_APT_CUTOFF, RST_APT_CUTOFF_PERMANENT);
        send_run(RUN_REPEAT, 8, 1'b0);
        wait_results();
    endtask

    // Adaptive proportion cutoffs on runs with a fixed low nibble
    task automatic test_proportion();
        set_cutoffs(RST_RCT_CUTOFF, RST_RCT_CUTOFF_PERMANENT, 10'd5, 10'd9);
        send_run(RUN_NIBBLE, 30, 1'b1);
        send_run(RUN_NOISE, 10, 1'b1);
        wait_results();
        set_cutoffs(RST_RCT_CUTOFF, RST_RCT_CUTOFF_PERMANENT, 10'd0, 10'd0);
        send_run(RUN_NIBBLE, 5, 1'b0);
        send_run(RUN_NOISE, 5, 1'b0);
        wait_results();
        set_cutoffs(RST_RCT_CUTOFF, RST_RCT_CUTOFF_PERMANENT, APT_MAX, 10'd1);
        send_run(RUN_NIBBLE, 5, 1'b1);
        wait_results();
        set_cutoffs(RST_RCT_CUTOFF, RST_RCT_CUTOFF_PERMANENT, 10'd1, APT_MAX);
        send_run(RUN_NIBBLE, 6, 1'b0);
        wait_results();
    endtask

    // Random settings per phase; mostly shaped runs, some noise
    task automatic test_random();
        int phase;
        int sent;
        int len;
        int pick;
        for (phase = 0; phase < 6; phase++)
        begin
            wait_results();
            set_mode($urandom_range(0, 7) != 0, $urandom_range(0, 3) != 0, 1'b0);
            set_cutoffs(pick_cut(int'(RCT_MAX)), pick_cut(int'(RCT_MAX)),
                        APT_W'(pick_cut(int'(APT_MAX))), APT_W'(pick_cut(int'(APT_MAX))));
            idle_on = (phase != 2);
            sent = 0;
            while (sent < 16)
            begin
                pick = $urandom_range(0, 9);
                len  = $urandom_range(2, 24);
                if (pick < 2)
                    send_run(RUN_NOISE, $urandom_range(1, 4), 1'($urandom_range(0, 1)));
                else if (pick < 4)
                    send_run(RUN_REPEAT, len, 1'($urandom_range(0, 1)));
                else if (pick < 6)
                    send_run(RUN_STEP, len, 1'($urandom_range(0, 1)));
                else if (pick < 7)
                    send_run(RUN_CURVE, len, 1'($urandom_range(0, 1)));
                else
                    send_run(RUN_NIBBLE, len, 1'($urandom_range(0, 1)));
                sent = sent + len;
                // now and then the sender holds off until the block is empty
                if ($urandom_range(0, 24) == 0)
                    wait_results();
            end
        end
        idle_on = 1'b1;
        wait_results();
    endtask

    // Long repetition run back to back through both cutoffs and the counter clear
    task automatic test_counter_top();
        set_mode(1'b1, 1'b1, 1'b0);
        set_cutoffs(16'd40, 16'd48, APT_MAX, APT_MAX);
        idle_on = 1'b0;
        send_run(RUN_REPEAT, 60, 1'b1);
        wait_results();
        idle_on = 1'b1;
    endtask

    // Halt flag latches on a permanent failure and stays set
    task automatic test_halt();
        set_cutoffs(16'd2, 16'd4, RST_APT_CUTOFF, RST_APT_CUTOFF_PERMANENT);
        set_mode(1'b1, 1'b1, 1'b1);
        send_run(RUN_NOISE, 3, 1'b1);
        send_run(RUN_REPEAT, 8, 1'b0);
        wait_results();
        set_mode(1'b1, 1'b1, 1'b0);
        send_run(RUN_REPEAT, 6, 1'b1);
        send_run(RUN_NOISE, 4, 1'b0);
        wait_results();
    endtask

    initial
    begin
        init_health_model();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_startup();
        test_bypass();
        test_plain_stuck();
        test_repetition();
        test_proportion();
        test_random();
        test_counter_top();
        test_halt();

        wait_results();
        repeat (8) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/emh_pkg.sv
rtl/core/emh_cfg_regs.sv
rtl/core/emh_calc.sv
rtl/core/entropy_health_monitor_core.sv
tb/tb_top.sv
